### hdl/ctfrag_pkg.sv
package ctfrag_pkg;

  localparam int PacketBytes    = 64;
  localparam int MaxPayload     = 7609;
  localparam int MaxContPackets = 128;
  localparam int InitHdr        = 7;
  localparam int ContHdr        = 5;
  localparam int InitRoom       = PacketBytes - InitHdr;
  localparam int ContRoom       = PacketBytes - ContHdr;
  localparam int Capacity       = InitRoom + MaxContPackets * ContRoom;
  localparam int UsableMax      = (MaxPayload < Capacity) ? MaxPayload : Capacity;

  localparam int LenW = 13;
  localparam int PosW = 6;
  localparam int SeqW = 7;
  localparam int IdxW = 3;

  localparam logic [LenW-1:0] LenMax  = LenW'(UsableMax);
  localparam logic [PosW-1:0] PosLast = PosW'(PacketBytes - 1);
  localparam logic [PosW-1:0] PosInit = PosW'(InitHdr);
  localparam logic [PosW-1:0] PosCont = PosW'(ContHdr);

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    JOB_ERR,
    JOB_INIT,
    JOB_CONT,
    JOB_DATA
  } job_kind_t;

  typedef struct packed {
    job_kind_t       kind;
    logic [31:0]     id;
    logic [7:0]      cmd;
    logic [LenW-1:0] len;
    logic [SeqW-1:0] seq;
    logic [7:0]      data;
    logic            last;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } queue_head_t;

  function automatic logic [IdxW-1:0] job_last_idx(input job_kind_t kind);
    logic [IdxW-1:0] r;
    unique case (kind)
      JOB_ERR:  r = IdxW'(0);
      JOB_INIT: r = IdxW'(InitHdr);
      JOB_CONT: r = IdxW'(ContHdr);
      JOB_DATA: r = IdxW'(0);
      default:  r = IdxW'(0);
    endcase
    return r;
  endfunction

endpackage

### hdl/ctfrag_front.sv
module ctfrag_front
  import ctfrag_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      payload_byte,
  input  logic            first_byte,
  input  logic [31:0]     channel_id,
  input  logic [7:0]      command,
  input  logic [LenW-1:0] payload_length,
  output logic            job_push,
  output job_t            job
);

  logic [LenW-1:0] bytes_left, bytes_left_next;
  logic [PosW-1:0] packet_position, packet_position_next;
  logic [SeqW-1:0] sequence_number, sequence_number_next;
  logic [31:0]     held_channel_id, held_channel_id_next;
  logic            message_active, message_active_next;

  logic [LenW-1:0] left_dec;
  logic            bad_len;

  always_comb begin
    bytes_left_next      = bytes_left;
    packet_position_next = packet_position;
    sequence_number_next = sequence_number;
    held_channel_id_next = held_channel_id;
    message_active_next  = message_active;
    job_push             = 1'b0;
    job                  = '0;
    job.kind             = JOB_DATA;
    job.data             = payload_byte;
    job.id               = held_channel_id;
    job.seq              = sequence_number;
    left_dec             = bytes_left - LenW'(1);
    bad_len              = (payload_length == '0) || (payload_length > LenMax);
    if (accept) begin
      if (first_byte) begin
        job_push = 1'b1;
        if (bad_len) begin
          job.kind             = JOB_ERR;
          message_active_next  = 1'b0;
          bytes_left_next      = '0;
          packet_position_next = '0;
          sequence_number_next = '0;
        end else begin
          left_dec             = payload_length - LenW'(1);
          job.kind             = JOB_INIT;
          job.id               = channel_id;
          job.cmd              = command;
          job.len              = payload_length;
          job.last             = (left_dec == '0);
          held_channel_id_next = channel_id;
          bytes_left_next      = left_dec;
          packet_position_next = PosInit;
          sequence_number_next = '0;
          message_active_next  = (left_dec != '0);
        end
      end else if (message_active) begin
        job_push        = 1'b1;
        job.last        = (left_dec == '0);
        bytes_left_next = left_dec;
        if (packet_position >= PosLast) begin
          job.kind             = JOB_CONT;
          sequence_number_next = sequence_number + SeqW'(1);
          packet_position_next = PosCont;
        end else begin
          packet_position_next = packet_position + PosW'(1);
        end
        message_active_next = (left_dec != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left      <= '0;
      packet_position <= '0;
      sequence_number <= '0;
      held_channel_id <= '0;
      message_active  <= 1'b0;
    end else begin
      bytes_left      <= bytes_left_next;
      packet_position <= packet_position_next;
      sequence_number <= sequence_number_next;
      held_channel_id <= held_channel_id_next;
      message_active  <= message_active_next;
    end
  end

endmodule

### hdl/ctfrag_queue.sv
module ctfrag_queue
  import ctfrag_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  job_t        wr_job,
  output logic        full,
  input  logic        rd_en,
  output queue_head_t head
);

  job_t                 slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr, rd_ptr;
  logic [QueueCntW-1:0] count;

  assign full = (count == QueueCntW'(QueueDepth));
  assign head = {(count != '0), slots[rd_ptr]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QueuePtrW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + QueuePtrW'(1);
      end
      priority if (wr_en && !rd_en) begin
        count <= count + QueueCntW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - QueueCntW'(1);
      end else begin
        count <= count;
      end
    end
  end

endmodule

### hdl/ctfrag_back.sv
module ctfrag_back
  import ctfrag_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  queue_head_t head,
  output logic        job_pop,
  output logic        out_valid,
  input  logic        out_taken,
  output logic [7:0]  out_byte,
  output logic        packet_start,
  output logic        message_end,
  output logic        length_error
);

  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] last_idx;
  logic            load;
  logic            done;
  logic [7:0]      id_byte;
  logic [31:0]     id_shift;
  logic [7:0]      byte_c;
  logic            start_c;
  logic            end_c;
  logic            err_c;

  assign last_idx = job_last_idx(head.job.kind);
  assign load     = head.valid && (!out_valid || out_taken);
  assign done     = (idx == last_idx);
  assign job_pop  = load && done;
  assign id_shift = head.job.id >> {~idx[1:0], 3'b000};
  assign id_byte  = id_shift[7:0];

  always_comb begin
    byte_c  = head.job.data;
    start_c = 1'b0;
    end_c   = 1'b0;
    err_c   = 1'b0;
    unique case (head.job.kind)
      JOB_ERR: begin
        byte_c = '0;
        err_c  = 1'b1;
      end
      JOB_INIT: begin
        start_c = (idx == '0);
        end_c   = done && head.job.last;
        priority if (!idx[2]) begin
          byte_c = id_byte;
        end else if (idx == IdxW'(4)) begin
          byte_c = head.job.cmd;
        end else if (idx == IdxW'(5)) begin
          byte_c = 8'(head.job.len >> 8);
        end else if (idx == IdxW'(6)) begin
          byte_c = head.job.len[7:0];
        end else begin
          byte_c = head.job.data;
        end
      end
      JOB_CONT: begin
        start_c = (idx == '0);
        end_c   = done && head.job.last;
        priority if (!idx[2]) begin
          byte_c = id_byte;
        end else if (idx == IdxW'(4)) begin
          byte_c = {1'b0, head.job.seq};
        end else begin
          byte_c = head.job.data;
        end
      end
      JOB_DATA: begin
        end_c = head.job.last;
      end
      default: begin
        byte_c = head.job.data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= byte_c;
      packet_start <= start_c;
      message_end  <= end_c;
      length_error <= err_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx <= done ? '0 : idx + IdxW'(1);
      end
      priority if (load) begin
        out_valid <= 1'b1;
      end else if (out_taken) begin
        out_valid <= 1'b0;
      end else begin
        out_valid <= out_valid;
      end
    end
  end

endmodule

### hdl/ctaphid_response_fragmenter.sv
// channel  | handshake        | fields
// ---------+------------------+------------------------------------------------
// input    | push / full      | payload_byte first_byte channel_id command
//          |                  | payload_length
// result   | empty / pop      | out_byte packet_start message_end length_error
//
// one result byte leaves per cycle while pop is high; an input transaction
// fans out to 0, 1, 6 or 8 result bytes, so with pop high input runs at one
// per cycle between packet headers; front classifies jobs into a four-entry
// job queue; back serializes jobs byte by byte into a single output register
// full rises only when the job queue fills; a stalled pop holds the output
// register and backs up through the queue
// synchronous reset empties queue and output and ends any active message
module ctaphid_response_fragmenter
  import ctfrag_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      payload_byte,
  input  logic            first_byte,
  input  logic [31:0]     channel_id,
  input  logic [7:0]      command,
  input  logic [LenW-1:0] payload_length,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_byte,
  output logic            packet_start,
  output logic            message_end,
  output logic            length_error
);

  logic        accept;
  logic        job_push;
  job_t        job;
  logic        job_pop;
  queue_head_t head;
  logic        out_valid;
  logic        out_taken;

  assign accept    = push && !full;
  assign empty     = !out_valid;
  assign out_taken = pop && out_valid;

  ctfrag_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .payload_byte   (payload_byte),
    .first_byte     (first_byte),
    .channel_id     (channel_id),
    .command        (command),
    .payload_length (payload_length),
    .job_push       (job_push),
    .job            (job)
  );

  ctfrag_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (job),
    .full   (full),
    .rd_en  (job_pop),
    .head   (head)
  );

  ctfrag_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .job_pop      (job_pop),
    .out_valid    (out_valid),
    .out_taken    (out_taken),
    .out_byte     (out_byte),
    .packet_start (packet_start),
    .message_end  (message_end),
    .length_error (length_error)
  );

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && length_error) |-> (out_byte == 8'h00 && !packet_start && !message_end))
    else $error("error result carries packet data");

  a_start_not_end: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(packet_start && message_end))
    else $error("header byte marked as message end");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("not empty after reset");

  a_pop_no_push: assert property (@(posedge clk) disable iff (rst)
    (job_pop && !job_push) |=> !full)
    else $error("queue full after a job left it");

endmodule

### verif/ctaphid_response_fragmenter_tb.sv
module ctaphid_response_fragmenter_tb;
  import ctfrag_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 16;

  typedef struct {
    logic [7:0] byte_val;
    logic       pkt_start;
    logic       msg_end;
    logic       len_err;
  } stream_byte_t;

  logic            clk = 1'b0;
  logic            rst;
  logic            push;
  logic            full;
  logic [7:0]      payload_byte;
  logic            first_byte;
  logic [31:0]     channel_id;
  logic [7:0]      command;
  logic [LenW-1:0] payload_length;
  logic            empty;
  logic            pop = 1'b0;
  logic [7:0]      out_byte;
  logic            packet_start;
  logic            message_end;
  logic            length_error;

  // fragmenter state as predicted
  logic [LenW-1:0] msg_left;
  logic [PosW-1:0] pkt_pos;
  logic [SeqW-1:0] cont_seq;
  logic [31:0]     msg_id;
  logic            msg_busy;

  stream_byte_t stream_bytes_due[$];
  int           mismatch_count = 0;
  int           items_sent = 0;
  int           stall_cycles = 0;
  int           send_idle_pct = 0;
  int           pop_stall_pct = 0;

  ctaphid_response_fragmenter i_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .payload_byte   (payload_byte),
    .first_byte     (first_byte),
    .channel_id     (channel_id),
    .command        (command),
    .payload_length (payload_length),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .packet_start   (packet_start),
    .message_end    (message_end),
    .length_error   (length_error)
  );

  always #1 clk = ~clk;

  function automatic void queue_stream_byte(input logic [7:0] b, input logic ps,
                                            input logic me, input logic le);
    stream_byte_t sb;
    sb.byte_val  = b;
    sb.pkt_start = ps;
    sb.msg_end   = me;
    sb.len_err   = le;
    stream_bytes_due.push_back(sb);
  endfunction

  function automatic void queue_channel_id();
    queue_stream_byte(msg_id[31:24], 1'b1, 1'b0, 1'b0);
    queue_stream_byte(msg_id[23:16], 1'b0, 1'b0, 1'b0);
    queue_stream_byte(msg_id[15:8], 1'b0, 1'b0, 1'b0);
    queue_stream_byte(msg_id[7:0], 1'b0, 1'b0, 1'b0);
  endfunction

  function automatic void fragment_item(input logic [7:0] data, input logic first,
                                        input logic [31:0] id, input logic [7:0] cmd,
                                        input logic [LenW-1:0] len);
    logic [LenW-1:0] len_hi;
    len_hi = len >> 8;
    if (first) begin
      if (len == '0 || len > LenMax) begin
        msg_busy = 1'b0;
        msg_left = '0;
        pkt_pos  = '0;
        cont_seq = '0;
        queue_stream_byte(8'h00, 1'b0, 1'b0, 1'b1);
        return;
      end
      msg_id = id;
      queue_channel_id();
      queue_stream_byte(cmd, 1'b0, 1'b0, 1'b0);
      queue_stream_byte(len_hi[7:0], 1'b0, 1'b0, 1'b0);
      queue_stream_byte(len[7:0], 1'b0, 1'b0, 1'b0);
      msg_busy = 1'b1;
      cont_seq = '0;
      msg_left = len;
      pkt_pos  = PosW'(InitHdr - 1);
    end else begin
      if (!msg_busy) return;
      // packet full, open a continuation packet
      if (pkt_pos >= PosLast) begin
        queue_channel_id();
        queue_stream_byte({1'b0, cont_seq}, 1'b0, 1'b0, 1'b0);
        cont_seq = cont_seq + SeqW'(1);
        pkt_pos  = PosW'(ContHdr - 1);
      end
    end
    msg_left = msg_left - LenW'(1);
    pkt_pos  = pkt_pos + PosW'(1);
    queue_stream_byte(data, 1'b0, msg_left == '0, 1'b0);
    if (msg_left == '0) msg_busy = 1'b0;
  endfunction

  task automatic check_stream_byte();
    stream_byte_t exp_b;
    if (stream_bytes_due.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected transaction: byte %h start %b end %b err %b",
                 out_byte, packet_start, message_end, length_error);
      return;
    end
    exp_b = stream_bytes_due.pop_front();
    if (out_byte !== exp_b.byte_val || packet_start !== exp_b.pkt_start ||
        message_end !== exp_b.msg_end || length_error !== exp_b.len_err) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch: expected byte %h start %b end %b err %b, got %h %b %b %b",
                 exp_b.byte_val, exp_b.pkt_start, exp_b.msg_end, exp_b.len_err,
                 out_byte, packet_start, message_end, length_error);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) check_stream_byte();
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input logic [7:0] data, input logic first, input logic [31:0] id,
                           input logic [7:0] cmd, input logic [LenW-1:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push           <= 1'b1;
    payload_byte   <= data;
    first_byte     <= first;
    channel_id     <= id;
    command        <= cmd;
    payload_length <= len;
    @(posedge clk);
    while (full) @(posedge clk);
    fragment_item(data, first, id, cmd, len);
    items_sent++;
  endtask

  // continuation bytes carry random header fields that must be ignored
  task automatic send_body(input int n);
    repeat (n) send_item(8'($urandom_range(255)), 1'b0, $urandom, 8'($urandom_range(255)),
                         LenW'($urandom_range(8191)));
  endtask

  task automatic send_message(input int len, input int count, input logic [31:0] id,
                              input logic [7:0] cmd);
    send_item(8'($urandom_range(255)), 1'b1, id, cmd, LenW'(len));
    send_body(count - 1);
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 12);
    if (r < 96) return $urandom_range(55, 70);
    return $urandom_range(110, 125);
  endfunction

  task automatic test_idle_and_bad_lengths();
    send_body(1);
    send_item(8'hA5, 1'b1, 32'h1234_5678, 8'h83, '0);
    send_body(1);
    send_item(8'h5A, 1'b1, '1, 8'hFF, LenW'(UsableMax + 1));
    send_item(8'hFF, 1'b1, '0, 8'h00, '1);
    send_body(2);
  endtask

  task automatic test_field_extremes();
    send_item(8'hFF, 1'b1, '1, 8'hFF, LenW'(1));
    send_item(8'h00, 1'b1, '0, 8'h00, LenW'(1));
    send_item(8'hFF, 1'b1, 32'hAAAA_5555, 8'h90, LenW'(2));
    send_item(8'h00, 1'b0, '1, 8'hFF, '1);
    send_message(3, 3, 32'h5555_AAAA, 8'h6F);
  endtask

  task automatic test_abandoned_message();
    send_message(int'(LenMax), 3, $urandom, 8'($urandom_range(255)));
    send_message(2, 2, $urandom, 8'($urandom_range(255)));
    send_message(6, 4, $urandom, 8'($urandom_range(255)));
    send_body(2);
  endtask

  // two continuation packets, the last one short
  task automatic test_long_message();
    send_message(150, 150, $urandom, 8'($urandom_range(255)));
  endtask

  task automatic test_random_traffic(input int n_items);
    int stop_at;
    int sel;
    int len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      sel = $urandom_range(99);
      len = pick_length();
      if (sel < 65) begin
        send_message(len, len, $urandom, 8'($urandom_range(255)));
      end else if (sel < 78) begin
        send_message(len, $urandom_range(1, len), $urandom, 8'($urandom_range(255)));
      end else if (sel < 88) begin
        send_item(8'($urandom_range(255)), 1'b1, $urandom, 8'($urandom_range(255)),
                  $urandom_range(1) ? '0 : LenW'($urandom_range(UsableMax + 1, 8191)));
      end else begin
        send_body($urandom_range(1, 3));
      end
    end
  endtask

  initial begin
    msg_left = '0;
    pkt_pos  = '0;
    cont_seq = '0;
    msg_id   = '0;
    msg_busy = 1'b0;
    rst            <= 1'b1;
    push           <= 1'b0;
    payload_byte   <= '0;
    first_byte     <= 1'b0;
    channel_id     <= '0;
    command        <= '0;
    payload_length <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_idle_and_bad_lengths();
    test_field_extremes();
    test_abandoned_message();
    test_long_message();
    test_random_traffic(35);

    send_idle_pct = 53;
    test_random_traffic(35);

    send_idle_pct = 0;
    pop_stall_pct = 53;
    test_random_traffic(35);

    send_idle_pct = 35;
    pop_stall_pct = 35;
    test_random_traffic(35);

    push <= 1'b0;
    while (stream_bytes_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0 && stream_bytes_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
hdl/ctfrag_pkg.sv
hdl/ctfrag_front.sv
hdl/ctfrag_queue.sv
hdl/ctfrag_back.sv
hdl/ctaphid_response_fragmenter.sv
verif/ctaphid_response_fragmenter_tb.sv
